### rtl/series_exp_log_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the series exp/log unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SERIES_EXP_LOG_UNIT_ASSERT_SVH
`define SERIES_EXP_LOG_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SELU_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define SELU_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define SELU_ASSERT_IMP(label, clk, rst_n, pre, post)
`define SELU_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

### rtl/selu_pkg.sv
// ----------------------------------------------------------------------------
// selu_pkg
// Types and constants shared by the series exp/log unit.
// ----------------------------------------------------------------------------
package selu_pkg;
  localparam int RES_W  = 56;
  localparam int X_W    = 29;
  localparam int EPS_W  = 25;
  localparam int CNT_W  = 7;
  localparam int MAG_W  = 64;

  localparam logic OP_EXP = 1'b0;
  localparam logic OP_LOG = 1'b1;

  localparam logic CFG_EPSILON   = 1'b0;
  localparam logic CFG_MAX_TERMS = 1'b1;

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // Request to the shared multiplier: floor(a*b / 2^shift), saturated
  typedef struct packed {
    logic                    start;
    logic signed [RES_W-1:0] a;
    logic signed [RES_W-1:0] b;
    logic                    shift32;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [RES_W-1:0] p;
  } mul_rsp_t;
endpackage

### rtl/selu_mul.sv
// ----------------------------------------------------------------------------
// selu_mul
// Shared multi-cycle signed multiplier with floor shift and 56-bit saturation.
// Uses one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module selu_mul
  import selu_pkg::*;
#(
  parameter int FRACTION_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);
  localparam int F_W = $clog2(33);

  logic        busy_r, busy_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        neg_r;
  logic        sh32_r;
  logic [63:0] ua_r, ub_r;
  logic [127:0] acc_r, acc_nxt;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] ppx;
  logic        done_r;
  logic signed [RES_W-1:0] p_r, p_nxt;
  logic [127:0] q, shmask;
  logic        rem_nz;
  logic [127:0] qn;
  logic [F_W-1:0] sh;

  // operand digit selection and partial product
  always_comb begin
    pa = step_r[0] ? ua_r[63:32] : ua_r[31:0];
    pb = step_r[1] ? ub_r[63:32] : ub_r[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    ppx = {64'd0, pp} << (32 * ({6'd0, step_r[0]} + {6'd0, step_r[1]}));
  end

  // final shift, floor and saturate
  always_comb begin
    sh     = sh32_r ? F_W'(32) : F_W'(FRACTION_BITS);
    q      = acc_r >> sh;
    shmask = (128'd1 << sh) - 128'd1;
    rem_nz = |(acc_r & shmask);
    qn     = q + {127'd0, rem_nz};
    if (!neg_r) begin
      p_nxt = (q > {72'd0, RES_MAX}) ? RES_MAX : RES_W'(q);
    end else begin
      p_nxt = (qn > {72'd0, 1'b1, 55'd0}) ? RES_MIN : RES_W'(-qn);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = 3'd0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt  = acc_r + ppx;
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd3) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= busy_r && (step_r == 3'd3);
    end
    acc_r <= acc_nxt;
    if (done_r) p_r <= p_nxt;
    if (req.start) begin
      neg_r  <= req.a[RES_W-1] ^ req.b[RES_W-1];
      sh32_r <= req.shift32;
      ua_r   <= req.a[RES_W-1] ? 64'(-{{8{req.a[RES_W-1]}}, req.a}) : 64'(req.a);
      ub_r   <= req.b[RES_W-1] ? 64'(-{{8{req.b[RES_W-1]}}, req.b}) : 64'(req.b);
    end
  end

  logic done2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) done2_r <= 1'b0;
    else        done2_r <= done_r;
  end

  assign rsp.done = done2_r;
  assign rsp.p    = p_r;

  `include "series_exp_log_unit_assert.svh"
  `SELU_ASSERT_NXT(a_start_busy, clk, rst_n, req.start, busy_r)
  `SELU_ASSERT_IMP(a_no_restart, clk, rst_n, busy_r, !req.start)
  `SELU_ASSERT_NXT(a_done_pulse, clk, rst_n, done2_r, !done2_r)
endmodule

### rtl/series_exp_log_unit.sv
// ----------------------------------------------------------------------------
// series_exp_log_unit
// Fixed-point exp and natural log by Taylor series on one shared multiplier.
// ----------------------------------------------------------------------------
// One item at a time: in_tready is high only while idle. Each multiply holds
// the shared multiplier through issue, four partial-product steps,
// floor/saturate and result. Exp costs two multiplies per term. Log costs one
// multiply per normalizing step (up to about 17), then two per term less one,
// plus one range check and one scale add. The result waits in an output
// register; there is no reset sweep.
module series_exp_log_unit
  import selu_pkg::*;
#(
  parameter int TERM_LIMIT    = 64,
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [28:0] x
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [55:0] result, [62:56] terms_used
  output logic        out_tuser,  // [0] domain_error
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [24:0] cfg_data
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NORM  = 3'd1;
  localparam logic [2:0] S_MULA  = 3'd2;
  localparam logic [2:0] S_MULB  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic signed [RES_W-1:0] ONE_Q = RES_W'(64'd1 << FRACTION_BITS);
  localparam logic signed [RES_W-1:0] C_INV_E =
    RES_W'((64'h5E2D58D8B3BCDF1B + (64'd1 << (63 - FRACTION_BITS))) >> (64 - FRACTION_BITS));
  localparam logic signed [RES_W-1:0] C_E =
    RES_W'((64'h2B7E151628AED2A7 + (64'd1 << (59 - FRACTION_BITS))) >> (60 - FRACTION_BITS));
  localparam logic signed [RES_W-1:0] C_LOW =
    RES_W'((64'd368 * (64'd1 << FRACTION_BITS) + 64'd500) / 64'd1000);
  localparam logic signed [RES_W:0] WIDE_MAX = {RES_MAX[RES_W-1], RES_MAX};
  localparam logic signed [RES_W:0] WIDE_MIN = {RES_MIN[RES_W-1], RES_MIN};

  logic [EPS_W-1:0] eps_r;
  logic [CNT_W-1:0] maxt_r;
  logic [2:0]       st_r;
  logic             op_r, err_r, issued_r, dir_up_r;
  logic [CNT_W-1:0] k_r, limit_r;
  logic signed [RES_W-1:0] xv_r, y_r, part_r, total_r, q_r;
  logic signed [7:0] n_r;
  mul_req_t req;
  mul_rsp_t rsp;
  logic signed [RES_W-1:0] term, sum, mag;
  logic signed [RES_W:0]  wide;
  logic [32:0]      rk;
  logic [32:0]      rtab [1 << CNT_W];
  logic             below;
  logic             norm_more;
  logic signed [X_W-1:0] xin;
  logic [CNT_W-1:0] lim_c;
  logic signed [RES_W:0]   fin_wide;
  logic signed [RES_W-1:0] fin_sum;

  selu_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign xin = in_tdata[X_W-1:0];

  // reciprocal table floor(2^32/k)
  assign rtab[0] = '0;
  for (genvar g = 1; g < (1 << CNT_W); g++) begin : g_rcp
    localparam logic [32:0] RCP = 33'(34'h1_0000_0000 / g);
    assign rtab[g] = RCP;
  end
  assign rk = rtab[k_r];

  // clamp the term limit
  always_comb begin
    lim_c = maxt_r;
    if (int'(maxt_r) > TERM_LIMIT) lim_c = CNT_W'(TERM_LIMIT);
    if (maxt_r == '0) lim_c = CNT_W'(1);
  end

  // term sign, saturating accumulate, stop test
  always_comb begin
    term  = (op_r == OP_LOG && !k_r[0]) ?
            ((rsp.p == RES_MIN) ? RES_MAX : -rsp.p) : rsp.p;
    wide  = {total_r[RES_W-1], total_r} + {term[RES_W-1], term};
    sum   = (wide > WIDE_MAX) ? RES_MAX :
            (wide < WIDE_MIN) ? RES_MIN : wide[RES_W-1:0];
    mag   = term[RES_W-1] ? -term : term;
    below = (term == RES_MIN) ? 1'b0 : ({1'b0, mag} < {32'd0, eps_r});
  end

  // log normalization still needed
  assign norm_more = dir_up_r ? (xv_r > ONE_Q) : (xv_r < C_LOW);

  // final scale add: n * 2^F
  assign fin_wide = {total_r[RES_W-1], total_r} +
                    ((RES_W+1)'(n_r) <<< FRACTION_BITS);
  assign fin_sum = (fin_wide > WIDE_MAX) ? RES_MAX :
                   (fin_wide < WIDE_MIN) ? RES_MIN :
                   fin_wide[RES_W-1:0];

  // multiplier requests
  always_comb begin
    req = '0;
    if (!issued_r) begin
      case (st_r)
        S_NORM: begin
          if (norm_more) begin
            req.start = 1'b1; req.a = xv_r; req.b = dir_up_r ? C_INV_E : C_E;
          end
        end
        S_MULA: begin
          req.start = 1'b1;
          req.a = (op_r == OP_EXP) ? part_r : part_r;
          req.b = (op_r == OP_EXP) ? xv_r : RES_W'({1'b0, rk});
          req.shift32 = (op_r == OP_LOG);
        end
        S_MULB: begin
          req.start = 1'b1;
          req.a = (op_r == OP_EXP) ? q_r : part_r;
          req.b = (op_r == OP_EXP) ? RES_W'({1'b0, rk}) : y_r;
          req.shift32 = (op_r == OP_EXP);
        end
        default: req = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r    <= EPS_W'(1);
      maxt_r   <= CNT_W'(64);
      st_r     <= S_IDLE;
      issued_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_EPSILON)   eps_r  <= cfg_data;
      if (cfg_we && cfg_index == CFG_MAX_TERMS) maxt_r <= cfg_data[CNT_W-1:0];
      if (req.start) issued_r <= 1'b1;
      if (rsp.done)  issued_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_tvalid) begin
          op_r    <= in_tuser;
          limit_r <= lim_c;
          k_r     <= CNT_W'(1);
          err_r   <= 1'b0;
          n_r     <= '0;
          xv_r    <= RES_W'(xin);
          dir_up_r <= (RES_W'(xin) > ONE_Q);
          if (in_tuser == OP_EXP) begin
            part_r <= ONE_Q; total_r <= ONE_Q; st_r <= S_MULA;
          end else if (xin <= 0) begin
            err_r <= 1'b1; total_r <= '0; k_r <= '0; st_r <= S_OUT;
          end else begin
            total_r <= '0; st_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (!issued_r && !norm_more) begin
            y_r <= xv_r - ONE_Q; part_r <= xv_r - ONE_Q; st_r <= S_MULA;
          end else if (rsp.done) begin
            xv_r <= rsp.p;
            n_r  <= dir_up_r ? n_r + 8'sd1 : n_r - 8'sd1;
          end
        end
        S_MULA: if (rsp.done) begin
          if (op_r == OP_EXP) begin
            q_r <= rsp.p; st_r <= S_MULB;
          end else begin
            total_r <= sum;
            if (below || k_r == limit_r) st_r <= S_FIN;
            else st_r <= S_MULB;
          end
        end
        S_MULB: if (rsp.done) begin
          if (op_r == OP_EXP) begin
            total_r <= sum; part_r <= rsp.p;
            if (below || k_r == limit_r) st_r <= S_OUT;
            else begin k_r <= k_r + CNT_W'(1); st_r <= S_MULA; end
          end else begin
            part_r <= rsp.p; k_r <= k_r + CNT_W'(1); st_r <= S_MULA;
          end
        end
        S_FIN: begin
          total_r <= fin_sum;
          st_r <= S_OUT;
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {1'b0, k_r, total_r};
  assign out_tuser  = err_r;

  `include "series_exp_log_unit_assert.svh"
  `SELU_ASSERT_IMP(a_err_zero, clk, rst_n, out_tvalid && out_tuser,
                   out_tdata[RES_W-1:0] == '0)
  `SELU_ASSERT_IMP(a_terms_bound, clk, rst_n, out_tvalid,
                   int'(out_tdata[62:56]) <= TERM_LIMIT)
  `SELU_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule
